>>> rtl/minute_bucket_rate_meter_defines.svh
// ----------------------------------------------------------------------------
// Minute bucket rate meter assertion macros
// Shared concurrent assertion helpers, clocked on clock, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef MINUTE_BUCKET_RATE_METER_DEFINES_SVH
`define MINUTE_BUCKET_RATE_METER_DEFINES_SVH

`ifndef SYNTH
`define MBRM_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbrm assertion failed");
`define MBRM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbrm assertion failed");
`else
`define MBRM_ASSERT_IMPLY(label, ante, cons)
`define MBRM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/mbrm_pkg.sv
// ----------------------------------------------------------------------------
// Minute bucket rate meter package
// Sizes, command codes and the interface structs between the blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrm_pkg;

   localparam int BUCKETS     = 16;
   localparam int POS_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SEC_PER_MIN = 60;
   localparam int BASE_SECS   = (BUCKETS - 1) * SEC_PER_MIN;
   localparam int SECS_W      = $clog2(BASE_SECS + 64);

   localparam int CMD_W    = 2;
   localparam int AMOUNT_W = 32;
   localparam int MINUTE_W = 12;
   localparam int SECOND_W = 6;
   localparam int TOTAL_W  = 40;
   localparam int DIV_CNT_W = $clog2(TOTAL_W + 1);

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic                rd_en;
      logic [POS_W-1:0]    rd_addr;
      logic                wr_en;
      logic [POS_W-1:0]    wr_addr;
      logic [AMOUNT_W-1:0] wr_data;
      logic                clear_all;
   } ram_req_type;

   typedef struct packed {
      logic               start;
      logic [TOTAL_W-1:0] dividend;
      logic [SECS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> rtl/mbrm_bucket_ram.sv
// ----------------------------------------------------------------------------
// Bucket store
// One-read one-write synchronous bucket memory with per-entry valid bits;
// an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "minute_bucket_rate_meter_defines.svh"

module mbrm_bucket_ram (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mbrm_pkg::ram_req_type         ram_req,
   output logic [mbrm_pkg::AMOUNT_W-1:0]      rd_data
);

   logic [mbrm_pkg::AMOUNT_W-1:0] mem [mbrm_pkg::BUCKETS];
   logic [mbrm_pkg::BUCKETS-1:0]  valid_ff;
   logic [mbrm_pkg::AMOUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= valid_ff[ram_req.rd_addr] ? mem[ram_req.rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ram_req.clear_all) begin
         valid_ff <= '0;
      end else if (ram_req.wr_en) begin
         valid_ff[ram_req.wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

   `MBRM_ASSERT_NEXT(a_clear_drops_all, ram_req.clear_all, valid_ff == '0)
   `MBRM_ASSERT_NEXT(a_write_marks_valid, ram_req.wr_en && !ram_req.clear_all,
                     valid_ff[$past(ram_req.wr_addr)])

endmodule

`default_nettype wire

>>> rtl/mbrm_divider.sv
// ----------------------------------------------------------------------------
// Rate divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "minute_bucket_rate_meter_defines.svh"

module mbrm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mbrm_pkg::div_req_type         div_req,
   output mbrm_pkg::div_status_type           div_status,
   output logic [mbrm_pkg::TOTAL_W-1:0]       quotient
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [mbrm_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [mbrm_pkg::SECS_W-1:0]     rem_ff, rem_in;
   logic [mbrm_pkg::SECS_W-1:0]     div_ff, div_in;
   logic [mbrm_pkg::TOTAL_W-1:0]    quo_ff, quo_in;
   logic [mbrm_pkg::SECS_W:0]       trial;
   logic                            take;

   always_comb begin
      trial = {rem_ff, quo_ff[mbrm_pkg::TOTAL_W-1]};
      take  = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = take ? mbrm_pkg::SECS_W'(trial - {1'b0, div_ff})
                       : mbrm_pkg::SECS_W'(trial);
         quo_in = {quo_ff[mbrm_pkg::TOTAL_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == mbrm_pkg::DIV_CNT_W'(mbrm_pkg::TOTAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign div_status.busy = busy_ff;
   assign div_status.done = done_ff;
   assign quotient        = quo_ff;

   `MBRM_ASSERT_NEXT(a_start_runs, div_req.start, busy_ff)
   `MBRM_ASSERT_IMPLY(a_done_idle, done_ff, !busy_ff)

endmodule

`default_nettype wire

>>> rtl/minute_bucket_rate_meter.sv
// ----------------------------------------------------------------------------
// Minute bucket rate meter
// Ring of per-minute buckets in a bucket memory, with total and per-second
// average on query.
// Sequencing: an add goes through S_ADD_RD, S_ADD_WR and S_RESP; a clear or an
// unused request goes straight to S_RESP; a query sweeps all 16 buckets through
// the memory read port, then runs the 40-bit bit-serial divider before S_RESP.
// One request at a time; the next is accepted once the response is staged.
// Synchronous reset clears position, stamp and all bucket valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "minute_bucket_rate_meter_defines.svh"

module minute_bucket_rate_meter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // amount[31:0], now_minute[43:32], now_second[49:44]
   input  wire logic [1:0]  req_tuser,  // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,  // window_total[39:0], rate_per_second[79:40]
   output logic [0:0]       rsp_tuser   // zero_divisor[0]
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_ADD_RD   = 7'b0000010,
      S_ADD_WR   = 7'b0000100,
      S_SUM      = 7'b0001000,
      S_SUM_LAST = 7'b0010000,
      S_DIV      = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   localparam logic [mbrm_pkg::POS_W-1:0] POS_LAST = mbrm_pkg::POS_W'(mbrm_pkg::BUCKETS - 1);

   state_type                         state_ff, state_in;
   logic [mbrm_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [mbrm_pkg::MINUTE_W-1:0]     stamp_ff, stamp_in;
   logic                              known_ff, known_in;
   logic                              fresh_ff, fresh_in;
   logic [mbrm_pkg::AMOUNT_W-1:0]     amount_ff, amount_in;
   logic [mbrm_pkg::SECOND_W-1:0]     second_ff, second_in;
   logic [mbrm_pkg::POS_W-1:0]        idx_ff, idx_in;
   logic                              rdv_ff, rdv_in;
   logic [mbrm_pkg::TOTAL_W-1:0]      acc_ff, acc_in;
   logic [mbrm_pkg::TOTAL_W-1:0]      rate_ff, rate_in;
   logic                              zdiv_ff, zdiv_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mbrm_pkg::TOTAL_W-1:0]      rsp_total_ff, rsp_total_in;
   logic [mbrm_pkg::TOTAL_W-1:0]      rsp_rate_ff, rsp_rate_in;
   logic                              rsp_zdiv_ff, rsp_zdiv_in;

   logic                              req_fire;
   logic [mbrm_pkg::CMD_W-1:0]        req_cmd;
   logic [mbrm_pkg::AMOUNT_W-1:0]     req_amount;
   logic [mbrm_pkg::MINUTE_W-1:0]     req_minute;
   logic [mbrm_pkg::SECOND_W-1:0]     req_second;
   logic [mbrm_pkg::POS_W-1:0]        pos_inc;
   logic [mbrm_pkg::TOTAL_W-1:0]      acc_sum;
   logic [mbrm_pkg::SECS_W-1:0]       divisor;
   logic                              rsp_load;

   mbrm_pkg::ram_req_type             ram_req;
   logic [mbrm_pkg::AMOUNT_W-1:0]     ram_rd_data;
   mbrm_pkg::div_req_type             div_req;
   mbrm_pkg::div_status_type          div_status;
   logic [mbrm_pkg::TOTAL_W-1:0]      div_quotient;

   mbrm_bucket_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   mbrm_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .div_req    (div_req),
      .div_status (div_status),
      .quotient   (div_quotient)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = req_tuser;
   assign req_amount = req_tdata[31:0];
   assign req_minute = req_tdata[43:32];
   assign req_second = req_tdata[49:44];

   assign pos_inc  = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
   assign acc_sum  = acc_ff + mbrm_pkg::TOTAL_W'(ram_rd_data);
   assign divisor  = mbrm_pkg::SECS_W'(mbrm_pkg::BASE_SECS) + mbrm_pkg::SECS_W'(second_ff);
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      stamp_in  = stamp_ff;
      known_in  = known_ff;
      fresh_in  = fresh_ff;
      amount_in = amount_ff;
      second_in = second_ff;
      idx_in    = idx_ff;
      rdv_in    = 1'b0;
      acc_in    = acc_ff;
      rate_in   = rate_ff;
      zdiv_in   = zdiv_ff;

      ram_req           = '0;
      div_req.start     = 1'b0;
      div_req.dividend  = acc_sum;
      div_req.divisor   = divisor;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               amount_in = req_amount;
               second_in = req_second;
               idx_in    = '0;
               acc_in    = '0;
               rate_in   = '0;
               zdiv_in   = 1'b0;
               fresh_in  = 1'b0;
               priority if (req_cmd == mbrm_pkg::CMD_ADD) begin
                  state_in = S_ADD_RD;
                  if (!known_ff) begin
                     stamp_in = req_minute;
                     known_in = 1'b1;
                  end else if (req_minute != stamp_ff) begin
                     pos_in   = pos_inc;
                     stamp_in = req_minute;
                     fresh_in = 1'b1;
                  end
               end else if (req_cmd == mbrm_pkg::CMD_QUERY) begin
                  state_in = S_SUM;
               end else if (req_cmd == mbrm_pkg::CMD_CLEAR) begin
                  ram_req.clear_all = 1'b1;
                  pos_in   = '0;
                  state_in = S_RESP;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_ADD_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = pos_ff;
            state_in        = S_ADD_WR;
         end
         S_ADD_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_ff;
            ram_req.wr_data = (fresh_ff ? '0 : ram_rd_data) + amount_ff;
            state_in        = S_RESP;
         end
         S_SUM: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_ff;
            rdv_in          = 1'b1;
            if (rdv_ff) begin
               acc_in = acc_sum;
            end
            if (idx_ff == POS_LAST) begin
               state_in = S_SUM_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SUM_LAST: begin
            acc_in = acc_sum;
            if (divisor == '0) begin
               zdiv_in  = 1'b1;
               state_in = S_RESP;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               rate_in  = div_quotient;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_zdiv_in  = rsp_zdiv_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = acc_ff;
         rsp_rate_in  = rate_ff;
         rsp_zdiv_in  = zdiv_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         stamp_ff     <= '0;
         known_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         stamp_ff     <= stamp_in;
         known_ff     <= known_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fresh_ff     <= fresh_in;
      amount_ff    <= amount_in;
      second_ff    <= second_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      rate_ff      <= rate_in;
      zdiv_ff      <= zdiv_in;
      rsp_total_ff <= rsp_total_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_zdiv_ff  <= rsp_zdiv_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_rate_ff, rsp_total_ff};
   assign rsp_tuser[0] = rsp_zdiv_ff;

   `MBRM_ASSERT_IMPLY(a_pos_in_ring, 1'b1, pos_ff <= POS_LAST)
   `MBRM_ASSERT_IMPLY(a_zdiv_rate_zero, rsp_valid_ff && rsp_zdiv_ff, rsp_rate_ff == '0)
   `MBRM_ASSERT_NEXT(a_request_leaves_idle, req_fire, state_ff != S_IDLE)
   `MBRM_ASSERT_IMPLY(a_div_quiet_in_idle, state_ff == S_IDLE, !div_status.busy)

endmodule

`default_nettype wire
